>>> rtl/bbp_pkg.sv
// ----------------------------------------------------------------------------
// bbp_pkg
// Types and constants shared by the bimodal branch predictor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bbp_pkg;

    localparam int WORD_W = 32;
    localparam int SRC_W  = WORD_W - 2;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_RESOLVE = 1'b1;

    localparam logic [1:0] TAKEN_THRESHOLD = 2'd2;
    localparam logic [1:0] COUNTER_MAX     = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] pc;
        logic              actual_taken;
        logic [WORD_W-1:0] actual_target;
        logic              pred_taken_in;
        logic [WORD_W-1:0] pred_target_in;
    } req_t;

    typedef struct packed {
        logic              pred_taken;
        logic [WORD_W-1:0] pred_target;
        logic              mispredict;
        logic              wrong_direction;
        logic              wrong_target;
        logic [WORD_W-1:0] prediction_count;
        logic [WORD_W-1:0] pred_taken_count;
        logic [WORD_W-1:0] mispredict_count;
        logic [WORD_W-1:0] direction_miss_count;
        logic [WORD_W-1:0] target_miss_count;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/bbp_req_if.sv
// ----------------------------------------------------------------------------
// bbp_req_if
// Valid/ready channel carrying predict and resolve requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbp_req_if;
    import bbp_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/bbp_rsp_if.sv
// ----------------------------------------------------------------------------
// bbp_rsp_if
// Valid/ready channel carrying predictor responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bbp_rsp_if;
    import bbp_pkg::*;

    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/bbp_ram.sv
// ----------------------------------------------------------------------------
// bbp_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/bbp_index.sv
// ----------------------------------------------------------------------------
// bbp_index
// Table index unit: word address modulo the table depth, by reciprocal
// multiply, back multiply and one correcting subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module bbp_index #(
    parameter int ENTRIES = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [bbp_pkg::SRC_W-1:0]    x,
    output logic                              idx_valid,
    output logic      [$clog2(ENTRIES)-1:0]   idx
);
    import bbp_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int PW    = 2 * SRC_W;
    localparam int QW    = SRC_W + IDX_W + 1;
    localparam logic [SRC_W-1:0] RECIP     = SRC_W'((64'd1 << SRC_W) / ENTRIES);
    localparam logic [IDX_W:0]   ENTRIES_C = (IDX_W + 1)'(ENTRIES);
    localparam logic [SRC_W-1:0] ENTRIES_W = SRC_W'(ENTRIES);

    logic             v1_reg, v2_reg, v3_reg;
    logic [SRC_W-1:0] x1_reg, x2_reg, x3_reg;
    logic [PW-1:0]    prod_reg;
    logic [SRC_W-1:0] qe_reg;
    logic [QW-1:0]    qe_full;
    logic [SRC_W-1:0] diff;
    logic [SRC_W-1:0] rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // quotient estimate is low by at most one
    assign qe_full = QW'(prod_reg[PW-1:SRC_W]) * QW'(ENTRIES_C);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x1_reg <= x;
        end
        prod_reg <= PW'(x1_reg) * PW'(RECIP);
        x2_reg   <= x1_reg;
        qe_reg   <= qe_full[SRC_W-1:0];
        x3_reg   <= x2_reg;
    end

    assign diff = x3_reg - qe_reg;
    assign rem  = (diff >= ENTRIES_W) ? diff - ENTRIES_W : diff;

    assign idx_valid = v3_reg;
    assign idx       = rem[IDX_W-1:0];

endmodule

`default_nettype wire

>>> rtl/bimodal_branch_predictor_btb_top.sv
// ----------------------------------------------------------------------------
// bimodal_branch_predictor_btb_top
// Bimodal 2-bit counter predictor with branch target buffer.
// A request passes the index unit, the counter and target RAM reads and the
// EXEC state, which waits while an earlier response is held; no new request
// is accepted until EXEC has registered the response.
// Reset: statistics clear at once; then a clearing pass zeroes every entry of
// both tables, during which no request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module bimodal_branch_predictor_btb_top #(
    parameter int ENTRIES = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bbp_req_if.sink    req,
    bbp_rsp_if.source  rsp
);
    import bbp_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_INDEX = 4'b0100,
        ST_EXEC  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    req_t              req_reg;
    rsp_t              rsp_data_reg, rsp_data_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [WORD_W-1:0] pred_total_reg, pred_total_next;
    logic [WORD_W-1:0] taken_total_reg, taken_total_next;
    logic [WORD_W-1:0] mis_total_reg, mis_total_next;
    logic [WORD_W-1:0] dir_miss_reg, dir_miss_next;
    logic [WORD_W-1:0] tgt_miss_reg, tgt_miss_next;

    logic              req_fire;
    logic              idx_valid;
    logic [IDX_W-1:0]  idx;
    logic              exec_go;

    logic              ctr_we, tgt_we, ram_re;
    logic [IDX_W-1:0]  waddr;
    logic [1:0]        ctr_wdata, ctr_rdata;
    logic [WORD_W-1:0] tgt_wdata, tgt_rdata;

    logic              wdir, wtgt, taken;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign exec_go   = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    bbp_index #(
        .ENTRIES (ENTRIES)
    ) u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req_fire),
        .x         (req.data.pc[WORD_W-1:2]),
        .idx_valid (idx_valid),
        .idx       (idx)
    );

    assign ram_re = (state_reg == ST_INDEX) && idx_valid;
    assign waddr  = (state_reg == ST_CLEAR) ? clr_reg : idx_reg;

    bbp_ram #(
        .WIDTH (2),
        .DEPTH (ENTRIES)
    ) u_ctr_ram (
        .clk   (clk),
        .we    (ctr_we),
        .waddr (waddr),
        .wdata (ctr_wdata),
        .re    (ram_re),
        .raddr (idx),
        .rdata (ctr_rdata)
    );

    bbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (tgt_we),
        .waddr (waddr),
        .wdata (tgt_wdata),
        .re    (ram_re),
        .raddr (idx),
        .rdata (tgt_rdata)
    );

    assign taken = (ctr_rdata >= TAKEN_THRESHOLD);
    assign wdir  = (req_reg.pred_taken_in != req_reg.actual_taken);
    assign wtgt  = !wdir && req_reg.pred_taken_in
                   && (req_reg.pred_target_in != req_reg.actual_target);

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        idx_next         = idx_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_data_next    = rsp_data_reg;
        pred_total_next  = pred_total_reg;
        taken_total_next = taken_total_reg;
        mis_total_next   = mis_total_reg;
        dir_miss_next    = dir_miss_reg;
        tgt_miss_next    = tgt_miss_reg;
        ctr_we           = 1'b0;
        tgt_we           = 1'b0;
        ctr_wdata        = '0;
        tgt_wdata        = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ctr_we   = 1'b1;
                tgt_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                if (idx_valid)
                begin
                    idx_next   = idx;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    rsp_data_next = '0;
                    if (req_reg.cmd == CMD_PREDICT)
                    begin
                        pred_total_next = pred_total_reg + 1'b1;
                        if (taken)
                        begin
                            taken_total_next = taken_total_reg + 1'b1;
                        end
                        rsp_data_next.pred_taken  = taken;
                        rsp_data_next.pred_target = tgt_rdata;
                    end
                    else
                    begin
                        if (wdir)
                        begin
                            dir_miss_next = dir_miss_reg + 1'b1;
                        end
                        else if (wtgt)
                        begin
                            tgt_miss_next = tgt_miss_reg + 1'b1;
                        end
                        if (wdir || wtgt)
                        begin
                            mis_total_next = mis_total_reg + 1'b1;
                        end
                        rsp_data_next.mispredict      = wdir || wtgt;
                        rsp_data_next.wrong_direction = wdir;
                        rsp_data_next.wrong_target    = wtgt;

                        // saturating step toward the actual direction
                        ctr_we = 1'b1;
                        if (req_reg.actual_taken)
                        begin
                            ctr_wdata = (ctr_rdata == COUNTER_MAX) ? COUNTER_MAX
                                                                   : ctr_rdata + 2'd1;
                        end
                        else
                        begin
                            ctr_wdata = (ctr_rdata == 2'd0) ? 2'd0 : ctr_rdata - 2'd1;
                        end
                        tgt_we    = req_reg.actual_taken;
                        tgt_wdata = req_reg.actual_target;
                    end
                    rsp_data_next.prediction_count     = pred_total_next;
                    rsp_data_next.pred_taken_count     = taken_total_next;
                    rsp_data_next.mispredict_count     = mis_total_next;
                    rsp_data_next.direction_miss_count = dir_miss_next;
                    rsp_data_next.target_miss_count    = tgt_miss_next;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            pred_total_reg  <= '0;
            taken_total_reg <= '0;
            mis_total_reg   <= '0;
            dir_miss_reg    <= '0;
            tgt_miss_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            rsp_valid_reg   <= rsp_valid_next;
            pred_total_reg  <= pred_total_next;
            taken_total_reg <= taken_total_next;
            mis_total_reg   <= mis_total_next;
            dir_miss_reg    <= dir_miss_next;
            tgt_miss_reg    <= tgt_miss_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req.data;
        end
        idx_reg      <= idx_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

`default_nettype wire
